// ===== hw/rtl/keyed_wait_queue_table_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the keyed wait queue table
// Shared wrappers for concurrent assertions clocked by clk and held off
// while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KEYED_WAIT_QUEUE_TABLE_CORE_MACROS_SVH
`define KEYED_WAIT_QUEUE_TABLE_CORE_MACROS_SVH

// The condition must never be true.
`define KWQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define KWQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KWQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kwq_pkg.sv =====
// ---------------------------------------------------------------------------
// kwq_pkg
// Command and status codes, field widths and the control structs shared by
// the keyed wait queue table modules.
// ---------------------------------------------------------------------------
`default_nettype none

package kwq_pkg;

  localparam int HANDLE_W    = 32;
  localparam int KIND_W      = 8;
  localparam int ID_W        = 64;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int TOTAL_W     = 9;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 80;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP_ONE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_ALL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_WAITER  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_KEY_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd3;

  localparam logic [ID_W-1:0] ID_NONE = '1;

  // Result of one key scan; hit and free_found are held until the next scan starts, done is a strobe.
  typedef struct packed {
    logic done;
    logic hit;
    logic free_found;
  } kwq_scan_res_t;

  // Slot table write request.
  typedef struct packed {
    logic we;
    logic valid;
  } kwq_slot_upd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kwq_waiter_mem.sv =====
// ---------------------------------------------------------------------------
// kwq_waiter_mem
// Waiter id storage: one write port and one read port with registered read
// data. Contents are undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module kwq_waiter_mem import kwq_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire logic [ID_W-1:0] wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output logic      [ID_W-1:0] rdata
);

  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/kwq_slot_table.sv =====
// ---------------------------------------------------------------------------
// kwq_slot_table
// Key slot memory with valid flags and one shared key comparator. A scan
// walks the slots one per cycle, stops at the first match and otherwise
// reports the lowest free slot.
// ---------------------------------------------------------------------------
`default_nettype none

module kwq_slot_table import kwq_pkg::*; #(
  parameter int KEY_SLOTS   = 16,
  parameter int SW          = 4,
  parameter int HW          = 4,
  parameter int CW          = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                scan_start,
  input  wire logic [HANDLE_W-1:0] scan_handle,
  input  wire logic [KIND_W-1:0]   scan_kind,
  output kwq_scan_res_t            scan_res,
  output logic      [SW-1:0]       res_slot,
  output logic      [HW-1:0]       res_head,
  output logic      [CW-1:0]       res_cnt,
  input  wire kwq_slot_upd_t       upd,
  input  wire logic [SW-1:0]       upd_slot,
  input  wire logic [HW-1:0]       upd_head,
  input  wire logic [CW-1:0]       upd_cnt
);

  localparam int KW = HANDLE_W + KIND_W;
  localparam int EW = KW + HW + CW;

  logic [EW-1:0]        mem [KEY_SLOTS];
  logic [EW-1:0]        rdata_r;
  logic [KEY_SLOTS-1:0] valid_r;
  logic [KW-1:0]        key_r;
  logic                 busy_r;
  logic                 cmp_pend_r;
  logic                 done_r;
  logic                 hit_r;
  logic                 free_found_r;
  logic [SW:0]          scan_idx_r;
  logic [SW-1:0]        cmp_idx_r;
  logic [SW-1:0]        free_idx_r;
  logic [SW-1:0]        slot_r;
  logic [HW-1:0]        head_r;
  logic [CW-1:0]        cnt_r;

  logic issue;
  logic cur_valid;
  logic cur_hit;
  logic cur_last;

  assign issue     = busy_r && (scan_idx_r < (SW+1)'(KEY_SLOTS));
  assign cur_valid = valid_r[cmp_idx_r];
  assign cur_hit   = cmp_pend_r && cur_valid && (rdata_r[KW-1:0] == key_r);
  assign cur_last  = cmp_pend_r && (cmp_idx_r == SW'(KEY_SLOTS - 1));

  // Entry layout from the lowest bit: handle, kind, head, count.
  always_ff @(posedge clk) begin
    if (upd.we) begin
      mem[upd_slot] <= {upd_cnt, upd_head, key_r};
    end
    if (issue) begin
      rdata_r <= mem[scan_idx_r[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      key_r        <= '0;
      busy_r       <= 1'b0;
      cmp_pend_r   <= 1'b0;
      done_r       <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      scan_idx_r   <= '0;
      cmp_idx_r    <= '0;
      free_idx_r   <= '0;
      slot_r       <= '0;
      head_r       <= '0;
      cnt_r        <= '0;
    end else begin
      done_r <= 1'b0;
      if (upd.we) begin
        valid_r[upd_slot] <= upd.valid;
      end
      if (scan_start) begin
        key_r        <= {scan_kind, scan_handle};
        busy_r       <= 1'b1;
        scan_idx_r   <= '0;
        cmp_pend_r   <= 1'b0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end else if (busy_r) begin
        cmp_pend_r <= issue;
        cmp_idx_r  <= scan_idx_r[SW-1:0];
        if (issue) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (cmp_pend_r && !cur_valid && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= cmp_idx_r;
        end
        if (cur_hit) begin
          hit_r      <= 1'b1;
          slot_r     <= cmp_idx_r;
          head_r     <= rdata_r[KW +: HW];
          cnt_r      <= rdata_r[KW+HW +: CW];
          busy_r     <= 1'b0;
          cmp_pend_r <= 1'b0;
          done_r     <= 1'b1;
        end else if (cur_last) begin
          // No match anywhere: hand back the lowest free slot, if any.
          slot_r     <= free_found_r ? free_idx_r : cmp_idx_r;
          head_r     <= '0;
          cnt_r      <= '0;
          busy_r     <= 1'b0;
          cmp_pend_r <= 1'b0;
          done_r     <= 1'b1;
        end
      end
    end
  end

  assign scan_res = '{done: done_r, hit: hit_r, free_found: free_found_r};
  assign res_slot = slot_r;
  assign res_head = head_r;
  assign res_cnt  = cnt_r;

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_wait_queue_table_core.sv =====
// ---------------------------------------------------------------------------
// keyed_wait_queue_table_core
// Flow: after the accept a key scan walks the slots, then a push or a miss
// answers from S_ACT, and each popped waiter takes an S_RD read and an S_EMIT.
// Throughput: one transaction at a time; in_tready is low until it completes.
// The single comparator scans one slot a cycle.
// Reset: synchronous, active low; clears all key valid flags, the total and out_tvalid.
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyed_wait_queue_table_core_macros.svh"

module keyed_wait_queue_table_core import kwq_pkg::*; #(
  parameter int KEY_SLOTS   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // command[1:0], object_handle[33:2], wait_kind[41:34], waiter_id[105:42]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // popped_id[63:0], status[65:64], waiting_total[74:66]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tlast
);

  localparam int SW   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW = CW + 1;
  localparam int NW   = KEY_SLOTS * QUEUE_DEPTH;
  localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int TW   = $clog2(NW + 1);
  localparam int TXW  = (TW > TOTAL_W) ? TW : TOTAL_W;
  localparam int PADW = OUT_TDATA_W - ID_W - STATUS_W - TOTAL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [CMD_W-1:0]    in_cmd;
  logic [HANDLE_W-1:0] in_handle;
  logic [KIND_W-1:0]   in_kind;
  logic [ID_W-1:0]     in_wid;

  assign in_cmd    = in_tdata[1:0];
  assign in_handle = in_tdata[33:2];
  assign in_kind   = in_tdata[41:34];
  assign in_wid    = in_tdata[105:42];

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [ID_W-1:0]     wid_r;
  logic [HW-1:0]       head_r;
  logic [CW-1:0]       cnt_r;
  logic [TW-1:0]       total_r;
  logic [TW-1:0]       total_nxt;
  logic                out_tvalid_r;
  logic [ID_W-1:0]     out_id_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;
  logic [TOTAL_W-1:0]  out_total_r;

  kwq_scan_res_t scan_res;
  kwq_slot_upd_t upd;
  logic [SW-1:0] tbl_slot;
  logic [HW-1:0] tbl_head;
  logic [CW-1:0] tbl_cnt;
  logic [HW-1:0] upd_head;
  logic [CW-1:0] upd_cnt;
  logic          scan_start;

  logic          w_we;
  logic          w_re;
  logic [AW-1:0] w_waddr;
  logic [AW-1:0] w_raddr;
  logic [ID_W-1:0] w_rdata;

  logic                out_free;
  logic                ld_out;
  logic [ID_W-1:0]     ld_id;
  logic [STATUS_W-1:0] ld_status;
  logic                ld_last;
  logic                pop_step;
  logic [AW-1:0]       base_addr;
  logic [HW-1:0]       push_head;
  logic [CW-1:0]       push_cnt;
  logic [SUMW-1:0]     tail_sum;
  logic [HW-1:0]       tail_idx;
  logic [SUMW-1:0]     head_inc;
  logic [HW-1:0]       head_next;
  logic [CW-1:0]       cnt_dec;
  logic [TXW-1:0]      total_ext;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  // A new key starts an empty queue at position zero.
  assign push_head = scan_res.hit ? head_r : '0;
  assign push_cnt  = scan_res.hit ? cnt_r : '0;
  assign base_addr = AW'(tbl_slot) * AW'(QUEUE_DEPTH);
  assign tail_sum  = SUMW'(push_head) + SUMW'(push_cnt);
  assign tail_idx  = (tail_sum >= SUMW'(QUEUE_DEPTH)) ?
                     HW'(tail_sum - SUMW'(QUEUE_DEPTH)) : HW'(tail_sum);
  assign head_inc  = SUMW'(head_r) + 1'b1;
  assign head_next = (head_inc >= SUMW'(QUEUE_DEPTH)) ? '0 : HW'(head_inc);
  assign cnt_dec   = cnt_r - 1'b1;
  assign w_waddr   = base_addr + AW'(tail_idx);
  assign w_raddr   = base_addr + AW'(head_r);
  assign total_ext = TXW'(total_nxt);

  always_comb begin
    state_nxt  = state_r;
    scan_start = 1'b0;
    ld_out     = 1'b0;
    ld_id      = ID_NONE;
    ld_status  = ST_OK;
    ld_last    = 1'b1;
    total_nxt  = total_r;
    upd        = '0;
    upd_head   = head_r;
    upd_cnt    = cnt_r;
    w_we       = 1'b0;
    w_re       = 1'b0;
    pop_step   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && (in_cmd != CMD_IGNORED)) begin
          scan_start = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        if (cmd_r == CMD_PUSH) begin
          if (out_free) begin
            ld_out    = 1'b1;
            state_nxt = S_IDLE;
            if (!scan_res.hit && !scan_res.free_found) begin
              ld_status = ST_KEY_FULL;
            end else if (scan_res.hit && (cnt_r == CW'(QUEUE_DEPTH))) begin
              ld_status = ST_QUEUE_FULL;
            end else begin
              w_we      = 1'b1;
              upd.we    = 1'b1;
              upd.valid = 1'b1;
              upd_head  = push_head;
              upd_cnt   = push_cnt + 1'b1;
              total_nxt = total_r + 1'b1;
            end
          end
        end else if (!scan_res.hit) begin
          if (out_free) begin
            ld_out    = 1'b1;
            ld_status = ST_NO_WAITER;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        w_re      = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ld_out    = 1'b1;
          ld_id     = w_rdata;
          ld_last   = (cmd_r == CMD_POP_ONE) || (cnt_dec == '0);
          total_nxt = total_r - 1'b1;
          upd.we    = 1'b1;
          upd.valid = (cnt_dec != '0);
          upd_head  = head_next;
          upd_cnt   = cnt_dec;
          pop_step  = 1'b1;
          state_nxt = ld_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (ld_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= in_cmd;
      wid_r <= in_wid;
    end
    if ((state_r == S_SCAN) && scan_res.done) begin
      head_r <= tbl_head;
      cnt_r  <= tbl_cnt;
    end else if (pop_step) begin
      head_r <= head_next;
      cnt_r  <= cnt_dec;
    end
    if (ld_out) begin
      out_id_r     <= ld_id;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
      out_total_r  <= total_ext[TOTAL_W-1:0];
    end
  end

  kwq_slot_table #(
    .KEY_SLOTS   (KEY_SLOTS),
    .SW          (SW),
    .HW          (HW),
    .CW          (CW)
  ) u_slot_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .scan_start  (scan_start),
    .scan_handle (in_handle),
    .scan_kind   (in_kind),
    .scan_res    (scan_res),
    .res_slot    (tbl_slot),
    .res_head    (tbl_head),
    .res_cnt     (tbl_cnt),
    .upd         (upd),
    .upd_slot    (tbl_slot),
    .upd_head    (upd_head),
    .upd_cnt     (upd_cnt)
  );

  kwq_waiter_mem #(
    .DEPTH (NW),
    .AW    (AW)
  ) u_waiter_mem (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (wid_r),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PADW{1'b0}}, out_total_r, out_status_r, out_id_r};

  `KWQ_ASSERT_NEVER(a_total_bound, total_r > TW'(NW), "waiter total exceeds capacity")
  `KWQ_ASSERT_IMPL(a_emit_nonempty, state_r == S_EMIT, cnt_r != '0, "pop from an empty queue")
  `KWQ_ASSERT_IMPL(a_done_in_scan, scan_res.done, state_r == S_SCAN, "scan ended outside a scan")
  `KWQ_ASSERT_NEXT(a_ignored_cmd, in_tready && in_tvalid && (in_cmd == CMD_IGNORED), state_r == S_IDLE && !(out_tvalid && !$past(out_tvalid)), "ignored command started work")

endmodule

`default_nettype wire
